### hdl/bcw_pkg.sv
// Package for the BLE CRC-24 and whitening encoder: item types, constants and bit functions.
`default_nettype none

package bcw_pkg;

  // Fixed field widths
  localparam int unsigned CRC_W  = 24;
  localparam int unsigned CHAN_W = 6;
  localparam int unsigned WHT_W  = 7;
  localparam int unsigned BYTE_W = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CRC_W;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_PRESET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_NUMBER = 2'd1;

  // Reset values and polynomials
  localparam logic [CRC_W-1:0]  CRC_POLY   = 24'h00065B;
  localparam logic [CRC_W-1:0]  CRC_RESET  = 24'h555555;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 6'd37;
  localparam logic [WHT_W-1:0]  WHT_TAP    = 7'h10;

  // Queue between front and back
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_AW    = $clog2(MID_DEPTH);
  localparam int unsigned MID_CW    = $clog2(MID_DEPTH + 1);

  // Result queue in the back end
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_crc;
    logic              end_of_packet;
  } out_item_t;

  // Classified item handed from front to back: CRC already folded in
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
    logic [CRC_W-1:0]  crc;
  } mid_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mid_stat_t;

  typedef struct packed {
    logic [CRC_W-1:0]  crc_preset;
    logic [CHAN_W-1:0] channel_number;
  } cfg_t;

  typedef struct packed {
    logic [WHT_W-1:0]  state;
    logic [BYTE_W-1:0] key;
  } wht_res_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

  // Seed: bit 0 set, channel MSB in bit 1 down to channel LSB in bit 6
  function automatic logic [WHT_W-1:0] wht_seed(input logic [CHAN_W-1:0] ch);
    logic [WHT_W-1:0] s;
    s[0] = 1'b1;
    for (int i = 0; i < CHAN_W; i++) begin
      s[i+1] = ch[CHAN_W-1-i];
    end
    return s;
  endfunction

  // Eight CRC bit steps, LSB of the byte first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = c;
    for (int j = 0; j < BYTE_W; j++) begin
      fb = r[CRC_W-1] ^ b[j];
      r  = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Eight whitening steps: rotate left, fold new bit 0 into bit 4
  function automatic wht_res_t wht_byte(input logic [WHT_W-1:0] w);
    wht_res_t         res;
    logic [WHT_W-1:0] s;
    s = w;
    for (int j = 0; j < BYTE_W; j++) begin
      s = {s[WHT_W-2:0], s[WHT_W-1]};
      if (s[0]) begin
        s = s ^ WHT_TAP;
      end
      res.key[j] = s[0];
    end
    res.state = s;
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/bcw_queue.sv
// Short queue carrying classified items from the CRC front end to the whitening back end.
`default_nettype none

module bcw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  bcw_pkg::mid_entry_t wr_data_i,
  input  logic                rd_i,
  output bcw_pkg::mid_entry_t rd_data_o,
  output bcw_pkg::mid_stat_t  stat_o
);

  bcw_pkg::mid_entry_t               mem_q [bcw_pkg::MID_DEPTH];
  logic [bcw_pkg::MID_AW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [bcw_pkg::MID_AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [bcw_pkg::MID_CW-1:0]        cnt_q, cnt_d;
  logic                              do_wr, do_rd;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == bcw_pkg::MID_CW'(bcw_pkg::MID_DEPTH));
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/bcw_front.sv
// Front end: accepts PDU bytes and folds each into the running CRC-24.
`default_nettype none

module bcw_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  bcw_pkg::in_item_t                    in_item_i,
  input  logic [bcw_pkg::CRC_W-1:0]            crc_preset_i,
  input  bcw_pkg::mid_stat_t                   q_stat_i,
  output logic                                 q_wr_o,
  output bcw_pkg::mid_entry_t                  q_data_o
);

  logic [bcw_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [bcw_pkg::CRC_W-1:0] crc_base;
  logic                      accept;

  assign accept = push_i && !q_stat_i.full;

  // CRC update; a first byte restarts from the preset
  always_comb begin
    crc_base = in_item_i.first_byte ? crc_preset_i : crc_q;
    crc_d    = crc_q;
    if (accept) begin
      crc_d = bcw_pkg::crc_byte(crc_base, in_item_i.data_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= bcw_pkg::CRC_RESET;
    end else begin
      crc_q <= crc_d;
    end
  end

  // Item with its post-byte CRC into the queue
  assign q_wr_o              = accept;
  assign q_data_o.data_byte  = in_item_i.data_byte;
  assign q_data_o.first_byte = in_item_i.first_byte;
  assign q_data_o.last_byte  = in_item_i.last_byte;
  assign q_data_o.crc        = bcw_pkg::crc_byte(crc_base, in_item_i.data_byte);

endmodule

`default_nettype wire

### hdl/bcw_back.sv
// Back end: whitens PDU bytes, appends the three CRC bytes and queues the results.
`default_nettype none

module bcw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bcw_pkg::mid_entry_t          head_i,
  input  bcw_pkg::mid_stat_t           q_stat_i,
  input  logic [bcw_pkg::CHAN_W-1:0]   channel_number_i,
  output logic                         q_rd_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output bcw_pkg::out_item_t           out_item_o
);

  // Byte phase of the head item
  localparam logic [1:0] PH_PDU  = 2'd0;
  localparam logic [1:0] PH_CRC0 = 2'd1;
  localparam logic [1:0] PH_CRC1 = 2'd2;
  localparam logic [1:0] PH_CRC2 = 2'd3;

  logic [1:0]                  phase_q, phase_d;
  logic [bcw_pkg::WHT_W-1:0]   wht_q, wht_d;
  logic [bcw_pkg::WHT_W-1:0]   wht_base;
  logic [bcw_pkg::BYTE_W-1:0]  src_byte;
  bcw_pkg::wht_res_t           wres;
  bcw_pkg::out_item_t          res;
  logic                        space, work, pop_acc;

  bcw_pkg::out_item_t          omem_q [bcw_pkg::OUT_DEPTH];
  logic [bcw_pkg::OUT_AW-1:0]  owr_ptr_q, ord_ptr_q;
  logic [bcw_pkg::OUT_CW-1:0]  ocnt_q, ocnt_d;

  assign empty_o    = (ocnt_q == '0);
  assign pop_acc    = pop_i && !empty_o;
  assign space      = (ocnt_q != bcw_pkg::OUT_CW'(bcw_pkg::OUT_DEPTH)) || pop_acc;
  assign work       = !q_stat_i.empty && space;
  assign out_item_o = omem_q[ord_ptr_q];

  // Byte selection and whitening
  always_comb begin
    wht_base          = (phase_q == PH_PDU && head_i.first_byte) ?
                        bcw_pkg::wht_seed(channel_number_i) : wht_q;
    src_byte          = head_i.data_byte;
    res.is_crc        = 1'b0;
    res.end_of_packet = 1'b0;
    phase_d           = phase_q;
    q_rd_o            = 1'b0;
    unique case (phase_q)
      PH_PDU: begin
        src_byte = head_i.data_byte;
        if (work) begin
          phase_d = head_i.last_byte ? PH_CRC0 : PH_PDU;
          q_rd_o  = !head_i.last_byte;
        end
      end
      PH_CRC0: begin
        src_byte   = bcw_pkg::rev8(head_i.crc[23:16]);
        res.is_crc = 1'b1;
        if (work) begin
          phase_d = PH_CRC1;
        end
      end
      PH_CRC1: begin
        src_byte   = bcw_pkg::rev8(head_i.crc[15:8]);
        res.is_crc = 1'b1;
        if (work) begin
          phase_d = PH_CRC2;
        end
      end
      PH_CRC2: begin
        src_byte          = bcw_pkg::rev8(head_i.crc[7:0]);
        res.is_crc        = 1'b1;
        res.end_of_packet = 1'b1;
        if (work) begin
          phase_d = PH_PDU;
          q_rd_o  = 1'b1;
        end
      end
      default: begin
        phase_d = PH_PDU;
      end
    endcase
    wres         = bcw_pkg::wht_byte(wht_base);
    res.out_byte = src_byte ^ wres.key;
    wht_d        = work ? wres.state : wht_q;
  end

  // Result queue fill count
  always_comb begin
    ocnt_d = ocnt_q;
    if (work && !pop_acc) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (!work && pop_acc) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PDU;
      wht_q     <= bcw_pkg::wht_seed(bcw_pkg::CHAN_RESET);
      owr_ptr_q <= '0;
      ord_ptr_q <= '0;
      ocnt_q    <= '0;
    end else begin
      phase_q <= phase_d;
      wht_q   <= wht_d;
      ocnt_q  <= ocnt_d;
      if (work) begin
        owr_ptr_q <= owr_ptr_q + 1'b1;
      end
      if (pop_acc) begin
        ord_ptr_q <= ord_ptr_q + 1'b1;
      end
    end
  end

  // Result storage, no reset
  always_ff @(posedge clk_i) begin
    if (work) begin
      omem_q[owr_ptr_q] <= res;
    end
  end

endmodule

`default_nettype wire

### hdl/ble_crc_whitening_encoder.sv
// Top level of the BLE CRC-24 and data whitening encoder.
//
// Input side is a queue: drive in_item_i and raise push; the byte is taken
// at a clock edge where full is low. Mark the first PDU byte with first_byte
// (reloads CRC from crc_preset and whitening from channel_number) and the
// final one with last_byte. Results come out of a queue: while empty is low
// out_item_o holds the oldest result; raise pop to take it.
// Each PDU byte gives one whitened byte; a last byte gives three more, the
// CRC bits 23 down to 0 in transmit order, flagged is_crc, the third with
// end_of_packet.
// Path: a byte taken by an idle block is written to the middle queue, then to
// the result queue, and then shows on the result ports. Throughput: one byte
// per cycle while neither queue backs up, set by the 8-bit-wide CRC and
// whitening steps; a last byte holds the whitening back end while its CRC bytes
// leave, and the four-entry queue in between keeps taking bytes meanwhile.
// Configuration: cfg_valid_i with cfg_index_i (0 crc_preset, 1 channel_number)
// and cfg_data_i; cfg_ready_o is always high. Write only while idle.
// Reset clears both queues and restores the preset 0x555555 and channel 37.
// A stalled receiver fills the result queue and then the middle queue, after
// which full rises; nothing is dropped.
`default_nettype none

module ble_crc_whitening_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  bcw_pkg::in_item_t                    in_item_i,
  output logic                                 empty,
  input  logic                                 pop,
  output bcw_pkg::out_item_t                   out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bcw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bcw_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  bcw_pkg::cfg_t       cfg_q;
  bcw_pkg::mid_stat_t  q_stat;
  bcw_pkg::mid_entry_t q_wr_data, q_head;
  logic                q_wr, q_rd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_preset     <= bcw_pkg::CRC_RESET;
      cfg_q.channel_number <= bcw_pkg::CHAN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bcw_pkg::REG_CRC_PRESET: begin
          cfg_q.crc_preset <= cfg_data_i[bcw_pkg::CRC_W-1:0];
        end
        bcw_pkg::REG_CHANNEL_NUMBER: begin
          cfg_q.channel_number <= cfg_data_i[bcw_pkg::CHAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign full = q_stat.full;

  bcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_item_i    (in_item_i),
    .crc_preset_i (cfg_q.crc_preset),
    .q_stat_i     (q_stat),
    .q_wr_o       (q_wr),
    .q_data_o     (q_wr_data)
  );

  bcw_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .rd_i      (q_rd),
    .rd_data_o (q_head),
    .stat_o    (q_stat)
  );

  bcw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (q_head),
    .q_stat_i         (q_stat),
    .channel_number_i (cfg_q.channel_number),
    .q_rd_o           (q_rd),
    .empty_o          (empty),
    .pop_i            (pop),
    .out_item_o       (out_item_o)
  );

endmodule

`default_nettype wire

### hdl/bcw_checker.sv
// Port-level checker for the BLE CRC-24 and whitening encoder, bound to the top level.
`default_nettype none

module bcw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty_i,
  input logic               pop_i,
  input bcw_pkg::out_item_t out_item_i
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty_i)
    else $error("result shown during reset");

  // End of packet only on a CRC byte
  a_eop_is_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (!out_item_i.end_of_packet || out_item_i.is_crc))
    else $error("end_of_packet on a PDU byte");

  // CRC bytes run without a gap up to end of packet
  a_crc_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_i && out_item_i.is_crc && !out_item_i.end_of_packet)
    |=> (!empty_i && out_item_i.is_crc))
    else $error("CRC byte sequence broken");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(out_item_i)))
    else $error("waiting result changed");

endmodule

bind ble_crc_whitening_encoder bcw_checker u_bcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty_i    (empty),
  .pop_i      (pop),
  .out_item_i (out_item_o)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the BLE CRC-24 and data whitening encoder.
`timescale 1ns / 100ps

module tb_top;

  // Spare register index: writes to it must leave the block unchanged
  localparam logic [bcw_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  // Own copies of the link-layer constants
  localparam logic [23:0] GEN_POLY        = 24'h00065B;
  localparam logic [23:0] PRESET_AT_RESET = 24'h555555;
  localparam logic [5:0]  CHAN_AT_RESET   = 6'd37;

  localparam int unsigned ITEMS_PER_PHASE = 52;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned HOLD_LEN        = 64;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned MAX_PRINTS      = 40;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       typed;
    logic [7:0] want;
  } dir_row_t;

  localparam int NDIR = 24;
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    '{8'h00, 1'b0, 1'b0, 1'b1, 8'h8D},  // straight after reset, no first mark
    '{8'hFF, 1'b1, 1'b0, 1'b1, 8'h72},  // reload, all ones
    '{8'hA5, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h5A, 1'b0, 1'b1, 1'b0, 8'h00},
    '{8'h3C, 1'b0, 1'b0, 1'b0, 8'h00},  // carries on past the CRC bytes
    '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00},  // one-byte PDU
    '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b1, 1'b0, 8'h00},  // last without a first
    '{8'h01, 1'b1, 1'b0, 1'b0, 8'h00},
    '{8'hFE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hC3, 1'b0, 1'b1, 1'b0, 8'h00},
    '{8'h40, 1'b1, 1'b0, 1'b0, 8'h00},  // advertising-like packet
    '{8'h06, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h11, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h22, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h33, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h44, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h66, 1'b0, 1'b1, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00},  // all-zero packet
    '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00},  // all-ones packet
    '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00}
  };

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           push        = 1'b0;
  logic                           full;
  bcw_pkg::in_item_t              in_item_i   = '0;
  logic                           empty;
  logic                           pop         = 1'b0;
  bcw_pkg::out_item_t             out_item_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [bcw_pkg::CFG_IDX_W-1:0]  cfg_index_i = bcw_pkg::REG_CRC_PRESET;
  logic [bcw_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Typed expectation travelling alongside the item on the input side
  logic       row_typed = 1'b0;
  logic [7:0] row_want  = '0;

  // Idle percentages and the one-shot receiver hold-off
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  logic        hold_kick    = 1'b0;
  int unsigned hold_cnt     = 0;

  // Predictor state and its copy of the registers
  logic [23:0] crc_state;
  logic [6:0]  wht_state;
  logic [23:0] cfg_preset;
  logic [5:0]  cfg_chan;

  bcw_pkg::out_item_t tx_expect_q [$];
  int unsigned err_cnt     = 0;
  int unsigned results_seen = 0;

  ble_crc_whitening_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Whitening seed: bit 0 set, channel bit 5 in bit 1 down to channel bit 0 in bit 6
  function automatic logic [6:0] wht_seed_of(input logic [5:0] ch);
    return {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], 1'b1};
  endfunction

  // Galois CRC-24, data bits taken LSB first
  function automatic logic [23:0] crc_after(input logic [23:0] c, input logic [7:0] b);
    logic [23:0] r;
    logic        fb;
    r = c;
    for (int j = 0; j < 8; j++) begin
      fb = r[23] ^ b[j];
      r  = {r[22:0], 1'b0};
      if (fb) begin
        r = r ^ GEN_POLY;
      end
    end
    return r;
  endfunction

  // x7+x4+1 whitening: rotate left, feed new bit 0 into bit 4, XOR it onto the data
  task automatic whiten(input logic [7:0] b, output logic [7:0] w);
    logic [6:0] s;
    s = wht_state;
    w = b;
    for (int j = 0; j < 8; j++) begin
      s    = {s[5:0], s[6]};
      s[4] = s[4] ^ s[0];
      w[j] = w[j] ^ s[0];
    end
    wht_state = s;
  endtask

  // One accepted PDU byte: its whitened copy, then the CRC bytes if it is the last
  task automatic encode_byte(input bcw_pkg::in_item_t it, input logic typed,
                             input logic [7:0] want);
    bcw_pkg::out_item_t r;
    logic [7:0]         grp;
    logic [7:0]         rv;
    if (it.first_byte) begin
      crc_state = cfg_preset;
      wht_state = wht_seed_of(cfg_chan);
    end
    crc_state = crc_after(crc_state, it.data_byte);
    whiten(it.data_byte, r.out_byte);
    r.is_crc        = 1'b0;
    r.end_of_packet = 1'b0;
    if (typed) begin
      r.out_byte = want;
    end
    tx_expect_q.push_back(r);
    if (it.last_byte) begin
      // CRC bit 23 goes out first, so each group is bit-reversed into its byte
      for (int k = 0; k < 3; k++) begin
        grp = crc_state[23-8*k -: 8];
        for (int j = 0; j < 8; j++) begin
          rv[j] = grp[7-j];
        end
        whiten(rv, r.out_byte);
        r.is_crc        = 1'b1;
        r.end_of_packet = (k == 2);
        tx_expect_q.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, results_seen, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted items and accepted results, in that order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bcw_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      cfg_preset = PRESET_AT_RESET;
      cfg_chan   = CHAN_AT_RESET;
      crc_state  = PRESET_AT_RESET;
      wht_state  = wht_seed_of(CHAN_AT_RESET);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bcw_pkg::REG_CRC_PRESET:     cfg_preset = cfg_data_i[23:0];
          bcw_pkg::REG_CHANNEL_NUMBER: cfg_chan   = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        encode_byte(in_item_i, row_typed, row_want);
      end
      if (pop && !empty) begin
        results_seen++;
        if (tx_expect_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", int'(out_item_o), 0);
        end else begin
          exp_item = tx_expect_q.pop_front();
          if (out_item_o.out_byte !== exp_item.out_byte) begin
            report_mismatch("out_byte", out_item_o.out_byte, exp_item.out_byte);
          end
          if (out_item_o.is_crc !== exp_item.is_crc) begin
            report_mismatch("is_crc", out_item_o.is_crc, exp_item.is_crc);
          end
          if (out_item_o.end_of_packet !== exp_item.end_of_packet) begin
            report_mismatch("end_of_packet", out_item_o.end_of_packet,
                            exp_item.end_of_packet);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pop, with one long hold-off once kicked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_kick && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      pop      <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run once nothing has moved for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one item; push stays high afterwards unless the next call idles
  task automatic send_item(input bcw_pkg::in_item_t it, input logic typed,
                           input logic [7:0] want);
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Mostly well-formed packets; the rest carry random first/last marks
  task automatic send_packet(inout int unsigned sent);
    bcw_pkg::in_item_t it;
    int unsigned       len;
    logic              well_formed;
    well_formed = ($urandom_range(99) < 85);
    len = ($urandom_range(99) < 5) ? $urandom_range(20, 39) : $urandom_range(1, 8);
    for (int unsigned i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom);
      if (well_formed) begin
        it.first_byte = (i == 0);
        it.last_byte  = (i == len - 1);
      end else begin
        it.first_byte = ($urandom_range(3) == 0);
        it.last_byte  = ($urandom_range(3) == 0);
      end
      send_item(it, 1'b0, 8'h00);
      sent++;
    end
  endtask

  task automatic write_reg(input logic [bcw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcw_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Wait until every expected item has come out, then let the pipeline settle
  task automatic wait_drained();
    @(posedge clk_i);
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bcw_pkg::in_item_t it;
    int unsigned       sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // New register settings, only once the block is idle
      if (ph > 0) begin
        push <= 1'b0;
        wait_drained();
        case (ph)
          1: begin
            write_reg(bcw_pkg::REG_CRC_PRESET, 24'h000000);
            write_reg(bcw_pkg::REG_CHANNEL_NUMBER, 24'd0);
          end
          2: begin
            write_reg(bcw_pkg::REG_CRC_PRESET, 24'hFFFFFF);
            write_reg(bcw_pkg::REG_CHANNEL_NUMBER, 24'd39);
          end
          3: begin
            write_reg(bcw_pkg::REG_CRC_PRESET, bcw_pkg::CFG_DATA_W'($urandom));
            write_reg(bcw_pkg::REG_CHANNEL_NUMBER, {18'h3FFFF, 6'd63});
            write_reg(REG_SPARE, bcw_pkg::CFG_DATA_W'($urandom));
          end
          4: begin
            write_reg(bcw_pkg::REG_CRC_PRESET, 24'h555555);
            write_reg(bcw_pkg::REG_CHANNEL_NUMBER, 24'd37);
          end
          default: begin
            write_reg(bcw_pkg::REG_CRC_PRESET, bcw_pkg::CFG_DATA_W'($urandom));
            write_reg(bcw_pkg::REG_CHANNEL_NUMBER,
                      {18'($urandom_range(18'h3FFFF)), 6'($urandom_range(63))});
          end
        endcase
        cfg_valid_i <= 1'b0;
      end

      // Sender busy, receiver slow; then the reverse; then no idling at all
      if (ph < 2) begin
        snd_idle_pct = 27;
        rcv_idle_pct = 85;
      end else if (ph < 4) begin
        snd_idle_pct = 85;
        rcv_idle_pct = 27;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      if (ph == 0) begin
        foreach (DIR_ROWS[r]) begin
          it.data_byte  = DIR_ROWS[r].data;
          it.first_byte = DIR_ROWS[r].first;
          it.last_byte  = DIR_ROWS[r].last;
          send_item(it, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end
      end

      // Receiver stops for a long stretch while packets keep coming
      if (ph == 4) begin
        hold_kick <= 1'b1;
      end

      // A byte with no first mark: new settings must not apply yet
      it.data_byte  = 8'($urandom);
      it.first_byte = 1'b0;
      it.last_byte  = 1'b0;
      send_item(it, 1'b0, 8'h00);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_packet(sent);
      end
    end

    push <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
